FILE: rtl/rrts_pkg.sv
package rrts_pkg;

	localparam int unsigned DEFAULT_SLOTS = 10;
	localparam logic [31:0] IDLE_ID = 32'hFFFF_FFFF;
	localparam logic [31:0] IDLE_STACK = 32'd100;
	localparam logic [31:0] FRAME_BYTES = 32'd64;
	localparam logic [31:0] RESCHED_START = 32'd100;
	// Last phase of the tick counter within one reschedule period of ten ticks.
	localparam logic [3:0] RESCHED_PH_LAST = 4'd9;
	localparam logic [4:0] PRIO_NONE = 5'd31;

	localparam logic [31:0] RST_STACK_BASE = 32'd537001984;
	localparam logic [31:0] RST_TOTAL_STACK = 32'd65536;
	localparam logic [31:0] RST_MAIN_STACK = 32'd1024;

	typedef enum logic [1:0] {
		REG_STACK_BASE = 2'd0,
		REG_TOTAL_STACK = 2'd1,
		REG_MAIN_STACK = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		FN_TICK = 4'd0,
		FN_SWITCH = 4'd1,
		FN_ADD = 4'd2,
		FN_PAUSE = 4'd3,
		FN_RESUME = 4'd4,
		FN_DELETE = 4'd5,
		FN_RESTART = 4'd6,
		FN_DELAY = 4'd7,
		FN_PRIO_ON = 4'd8,
		FN_PRIO_OFF = 4'd9,
		FN_INIT = 4'd10,
		FN_START = 4'd11
	} func_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_DUP_ID = 3'd2,
		ST_DUP_ENTRY = 3'd3,
		ST_FULL = 3'd4,
		ST_NO_STACK = 3'd5,
		ST_SELF = 3'd6,
		ST_ALREADY = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		MODE_RUN = 2'd0,
		MODE_PAUSE = 2'd1,
		MODE_PRIO = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_OUT
	} state_t;

	// One slot as it travels around the ring.
	typedef struct packed {
		logic valid;
		logic [31:0] id;
		logic [31:0] entry;
		logic [31:0] sp;
		logic [1:0] mode;
		logic [31:0] wake;
		logic [31:0] stack_top;
	} slot_t;

	// Write command that the controller aims at the slot sitting at the ring head.
	typedef struct packed {
		logic rotate;
		logic clear_all;
		logic wr;
		slot_t data;
	} ring_ctl_t;

endpackage

FILE: rtl/rrts_if.sv
interface rrts_cmd_if;
	logic valid;
	logic ready;
	logic [3:0] func;
	logic [31:0] task_id;
	logic [31:0] entry_addr;
	logic [31:0] stack_bytes;
	logic [31:0] saved_sp;
	logic [31:0] delay_ticks;
	modport source (output valid, func, task_id, entry_addr, stack_bytes, saved_sp,
		delay_ticks, input ready);
	modport sink (input valid, func, task_id, entry_addr, stack_bytes, saved_sp,
		delay_ticks, output ready);
endinterface

interface rrts_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [31:0] next_sp;
	logic [31:0] frame_top;
	logic resched_req;
	logic [3:0] cur_slot;
	modport source (output valid, status, next_sp, frame_top, resched_req, cur_slot,
		input ready);
	modport sink (input valid, status, next_sp, frame_top, resched_req, cur_slot,
		output ready);
endinterface

FILE: rtl/round_robin_task_scheduler_core.sv
// Channel  Dir  Handshake    Payload
// cmd      in   valid/ready  func, task_id, entry_addr, stack_bytes, saved_sp, delay_ticks
// rsp      out  valid/ready  status, next_sp, frame_top, resched_req, cur_slot
// cfg      in   cfg_we       cfg_idx, cfg_data (stack base, stack budget, main stack reserve)
//
// The slot table is a ring of SLOTS cells that rotates by one slot a cycle while a
// command scans the table or seeks its target. Every command first takes one full
// revolution to scan the table, then up to SLOTS-1 more rotations bring the target
// slot to the head, where the execute step acts on it and fills the response
// register; the response is then raised valid and held in the output state.
// Reset clears the valid bits and the scheduler registers at once; no pass.
// A new command is taken only after the response of the previous one has been
// taken, so response back-pressure simply holds the block.
module round_robin_task_scheduler_core #(
	parameter int unsigned SLOTS = rrts_pkg::DEFAULT_SLOTS
) (
	input logic clk,
	input logic arst_n,
	rrts_cmd_if.sink cmd,
	rrts_rsp_if.source rsp,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [31:0] cfg_data
);
	import rrts_pkg::*;

	localparam int unsigned PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);

	// Configuration registers.
	logic [31:0] stack_base_q, total_stack_q, main_stack_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_base_q <= RST_STACK_BASE;
			total_stack_q <= RST_TOTAL_STACK;
			main_stack_q <= RST_MAIN_STACK;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_STACK_BASE: stack_base_q <= cfg_data;
				REG_TOTAL_STACK: total_stack_q <= cfg_data;
				REG_MAIN_STACK: main_stack_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Scheduler state.
	state_t state_q, state_d;
	logic [PW-1:0] head_q;     // slot number sitting in cell 0
	logic [PW-1:0] cnt_q;      // rotations done in this revolution
	logic [3:0] cur_q;
	logic [4:0] prio_q;
	logic [31:0] tick_q, used_q;
	logic [3:0] tick_ph_q;     // tick count modulo the reschedule period
	logic run_q;

	// Captured command.
	logic [3:0] func_q;
	logic [31:0] id_q, entry_q, bytes_q, sp_in_q, dly_q;

	// Scan results.
	logic id_hit_q, entry_hit_q, free_hit_q, sel_hit_q;
	logic [PW-1:0] id_slot_q, free_slot_q, sel_slot_q;
	logic [31:0] sel_sp_q, zero_sp_q;
	logic ex_done_q;

	// Response register.
	logic rsp_valid_q;
	logic [2:0] status_q;
	logic [31:0] next_sp_q, top_q;
	logic resched_q;

	ring_ctl_t ctl;
	slot_t head;

	rrts_ring #(.SLOTS(SLOTS)) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.head(head)
	);

	// Round-robin base: the last slot wraps to slot 0 before the scan.
	logic [PW-1:0] rr_base;
	assign rr_base = (cur_q[PW-1:0] == LAST) ? '0 : cur_q[PW-1:0];

	// Distance of the head slot after the base, 1..SLOTS-1 for scanned slots.
	logic [PW:0] rr_dist;
	always_comb begin
		if (head_q > rr_base) begin
			rr_dist = {1'b0, head_q} - {1'b0, rr_base};
		end else begin
			rr_dist = {1'b0, head_q} + (PW+1)'(SLOTS) - {1'b0, rr_base};
		end
	end

	logic sel_ok;
	always_comb begin
		sel_ok = head.valid && (head.mode != MODE_PAUSE) && (head.wake <= tick_q);
		if (prio_q != PRIO_NONE && prio_q != 5'd0 && prio_q != 5'(head_q)) begin
			sel_ok = 1'b0;
		end
		if (head_q == rr_base) begin
			sel_ok = 1'b0;
		end
	end

	// Distance of the current best selection.
	logic [PW:0] sel_dist;
	always_comb begin
		if (sel_slot_q > rr_base) begin
			sel_dist = {1'b0, sel_slot_q} - {1'b0, rr_base};
		end else begin
			sel_dist = {1'b0, sel_slot_q} + (PW+1)'(SLOTS) - {1'b0, rr_base};
		end
	end

	// Slot that a switch makes current; slot 0 when nothing qualifies.
	logic [3:0] sw_cur;
	assign sw_cur = sel_hit_q ? 4'(sel_slot_q) : 4'd0;

	// Which slot the execute step works on. A lookup that missed works on the
	// current slot, where it only reports its status.
	logic [PW-1:0] tgt_d;
	always_comb begin
		unique case (func_q) inside
			FN_ADD, FN_INIT: tgt_d = free_hit_q ? free_slot_q : cur_q[PW-1:0];
			FN_PAUSE, FN_RESUME, FN_DELETE, FN_RESTART: begin
				tgt_d = id_hit_q ? id_slot_q : cur_q[PW-1:0];
			end
			FN_START: tgt_d = '0;
			default: tgt_d = cur_q[PW-1:0];
		endcase
	end

	logic at_target;
	assign at_target = (head_q == tgt_d);

	// Budget check for add and init.
	logic [31:0] req_bytes, used_base, used_new;
	logic no_stack;
	always_comb begin
		req_bytes = (func_q == FN_INIT) ? IDLE_STACK : bytes_q;
		used_base = (func_q == FN_INIT) ? main_stack_q : used_q;
		no_stack = (used_base > total_stack_q) || ((total_stack_q - used_base) < req_bytes);
		used_new = used_base + req_bytes;
	end

	// Phase of the tick counter after one more tick; the 32-bit wrap lands on zero.
	logic [3:0] tick_ph_d;
	always_comb begin
		if (tick_q == '1 || tick_ph_q == RESCHED_PH_LAST) begin
			tick_ph_d = '0;
		end else begin
			tick_ph_d = tick_ph_q + 4'd1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (cmd.valid && cmd.ready) state_d = S_SCAN;
			S_SCAN: if (cnt_q == LAST) state_d = S_EXEC;
			S_EXEC: if (ex_done_q) state_d = S_OUT;
			S_OUT: if (rsp.ready || !rsp_valid_q) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// The ring is clocked on every scan cycle and every execute cycle not at the target.
	logic ex_fire;
	assign ex_fire = (state_q == S_EXEC) && !ex_done_q && at_target;

	// Write decision at the head, and the response it produces.
	slot_t wr_slot;
	logic do_wr, do_clear;
	logic [2:0] st_d;
	logic [31:0] nsp_d, top_d;
	logic rs_d;
	always_comb begin
		wr_slot = head;
		do_wr = 1'b0;
		do_clear = 1'b0;
		st_d = ST_OK;
		nsp_d = '0;
		top_d = '0;
		rs_d = 1'b0;
		case (func_q) inside
			FN_TICK: begin
				rs_d = run_q && ((tick_q + 32'd1) >= RESCHED_START) && (tick_ph_d == '0);
			end
			FN_SWITCH: begin
				// The pointer just saved is the answer when the current slot is
				// picked again; otherwise the scan kept the chosen slot's pointer.
				do_wr = 1'b1;
				wr_slot.sp = sp_in_q;
				if (sw_cur == cur_q) nsp_d = sp_in_q;
				else if (sel_hit_q) nsp_d = sel_sp_q;
				else nsp_d = zero_sp_q;
			end
			FN_ADD, FN_INIT: begin
				if (func_q == FN_ADD && id_hit_q) st_d = ST_DUP_ID;
				else if (func_q == FN_ADD && entry_hit_q) st_d = ST_DUP_ENTRY;
				else if (func_q == FN_ADD && !free_hit_q) st_d = ST_FULL;
				else if (no_stack) st_d = ST_NO_STACK;
				else begin
					do_wr = 1'b1;
					wr_slot.valid = 1'b1;
					wr_slot.id = (func_q == FN_INIT) ? IDLE_ID : id_q;
					wr_slot.entry = entry_q;
					wr_slot.stack_top = stack_base_q - used_new;
					wr_slot.sp = stack_base_q - used_new - FRAME_BYTES;
					wr_slot.mode = MODE_RUN;
					wr_slot.wake = '0;
					top_d = stack_base_q - used_new;
				end
			end
			FN_PAUSE: begin
				if (!id_hit_q) st_d = ST_NOT_FOUND;
				else if (head.mode == MODE_PAUSE) st_d = ST_ALREADY;
				else begin
					do_wr = 1'b1;
					wr_slot.mode = MODE_PAUSE;
					rs_d = (4'(id_slot_q) == cur_q);
				end
			end
			FN_RESUME: begin
				if (!id_hit_q) st_d = ST_NOT_FOUND;
				else if (head.mode == MODE_RUN) st_d = ST_ALREADY;
				else begin
					do_wr = 1'b1;
					wr_slot.mode = MODE_RUN;
				end
			end
			FN_DELETE: begin
				if (!id_hit_q) st_d = ST_NOT_FOUND;
				else if (4'(id_slot_q) == cur_q) st_d = ST_SELF;
				else begin
					do_wr = 1'b1;
					wr_slot.valid = 1'b0;
				end
			end
			FN_RESTART: begin
				if (!id_hit_q) st_d = ST_NOT_FOUND;
				else if (4'(id_slot_q) == cur_q) st_d = ST_SELF;
				else begin
					do_wr = 1'b1;
					wr_slot.mode = MODE_RUN;
					wr_slot.wake = '0;
					wr_slot.sp = head.stack_top - FRAME_BYTES;
					top_d = head.stack_top;
				end
			end
			FN_DELAY: begin
				if (cur_q != 4'd0) begin
					do_wr = 1'b1;
					wr_slot.wake = tick_q + dly_q;
					rs_d = 1'b1;
				end
			end
			FN_PRIO_ON: begin
				if (head.mode == MODE_PRIO) st_d = ST_ALREADY;
				else begin
					do_wr = 1'b1;
					wr_slot.mode = MODE_PRIO;
				end
			end
			FN_PRIO_OFF: begin
				if (head.mode == MODE_RUN) st_d = ST_ALREADY;
				else begin
					do_wr = 1'b1;
					wr_slot.mode = MODE_RUN;
				end
			end
			FN_START: nsp_d = head.sp;
			default: ;
		endcase
		if (func_q == FN_INIT) do_clear = 1'b1;
	end

	// Ring controls. Init clears all valid bits on the first scan cycle, before
	// the free-slot search, so the idle task always lands in slot 0.
	logic init_clear;
	assign init_clear = (state_q == S_SCAN) && (cnt_q == '0) && (func_q == FN_INIT);

	always_comb begin
		ctl.rotate = (state_q == S_SCAN) || ((state_q == S_EXEC) && !ex_done_q && !at_target);
		ctl.clear_all = init_clear && do_clear;
		ctl.wr = ex_fire && do_wr;
		ctl.data = wr_slot;
	end

	assign cmd.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			cnt_q <= '0;
			cur_q <= '0;
			prio_q <= PRIO_NONE;
			tick_q <= '0;
			tick_ph_q <= '0;
			used_q <= '0;
			run_q <= 1'b0;
			ex_done_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.rotate) begin
				head_q <= (head_q == LAST) ? '0 : head_q + PW'(1);
			end
			if (state_q == S_IDLE) begin
				cnt_q <= '0;
				ex_done_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				cnt_q <= cnt_q + PW'(1);
			end
			if (ex_fire) begin
				ex_done_q <= 1'b1;
				unique case (func_t'(func_q))
					FN_TICK: begin
						if (run_q) begin
							tick_q <= tick_q + 32'd1;
							tick_ph_q <= tick_ph_d;
						end
					end
					FN_SWITCH: cur_q <= sw_cur;
					FN_ADD: if (st_d == ST_OK) used_q <= used_new;
					FN_INIT: begin
						used_q <= (st_d == ST_OK) ? used_new : main_stack_q;
						cur_q <= '0;
						tick_q <= '0;
						tick_ph_q <= '0;
						run_q <= 1'b0;
					end
					FN_START: begin
						cur_q <= '0;
						run_q <= 1'b1;
					end
					FN_PRIO_ON: if (st_d == ST_OK) prio_q <= 5'(cur_q);
					FN_PRIO_OFF: if (st_d == ST_OK) prio_q <= PRIO_NONE;
					default: ;
				endcase
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end else if (state_q == S_EXEC && ex_done_q) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_q <= cmd.func;
			id_q <= cmd.task_id;
			entry_q <= cmd.entry_addr;
			bytes_q <= cmd.stack_bytes;
			sp_in_q <= cmd.saved_sp;
			dly_q <= cmd.delay_ticks;
			id_hit_q <= 1'b0;
			entry_hit_q <= 1'b0;
			free_hit_q <= 1'b0;
			sel_hit_q <= 1'b0;
		end
		if (state_q == S_SCAN) begin
			// Lowest slot number wins for id and free slot, as in a forward search.
			if (head.valid && !init_clear && head.id == id_q
				&& (!id_hit_q || head_q < id_slot_q)) begin
				id_hit_q <= 1'b1;
				id_slot_q <= head_q;
			end
			if (head.valid && !init_clear && head.entry == entry_q) entry_hit_q <= 1'b1;
			if ((!head.valid || init_clear) && (!free_hit_q || head_q < free_slot_q)) begin
				free_hit_q <= 1'b1;
				free_slot_q <= head_q;
			end
			if (sel_ok && (!sel_hit_q || rr_dist < sel_dist)) begin
				sel_hit_q <= 1'b1;
				sel_slot_q <= head_q;
				sel_sp_q <= head.sp;
			end
			// Slot 0 is the fallback of a switch that finds nothing to run.
			if (head_q == '0) zero_sp_q <= head.sp;
		end
		if (ex_fire) begin
			status_q <= st_d;
			next_sp_q <= nsp_d;
			top_q <= top_d;
			resched_q <= rs_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.next_sp = next_sp_q;
	assign rsp.frame_top = top_q;
	assign rsp.resched_req = resched_q;
	assign rsp.cur_slot = cur_q;
endmodule

FILE: rtl/rrts_cell.sv
module rrts_cell (
	input logic clk,
	input logic arst_n,
	input logic rotate,
	input logic clear_all,
	input logic wr,
	input rrts_pkg::slot_t wr_data,
	input rrts_pkg::slot_t from_prev,
	output rrts_pkg::slot_t slot
);
	import rrts_pkg::*;

	slot_t data_q;
	logic valid_q;

	// Valid bit is control state; the rest of the slot is payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear_all) begin
			valid_q <= 1'b0;
		end else if (wr) begin
			valid_q <= wr_data.valid;
		end else if (rotate) begin
			valid_q <= from_prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			data_q <= wr_data;
		end else if (rotate) begin
			data_q <= from_prev;
		end
	end

	always_comb begin
		slot = data_q;
		slot.valid = valid_q;
	end
endmodule

FILE: rtl/rrts_ring.sv
module rrts_ring #(
	parameter int unsigned SLOTS = rrts_pkg::DEFAULT_SLOTS
) (
	input logic clk,
	input logic arst_n,
	input rrts_pkg::ring_ctl_t ctl,
	output rrts_pkg::slot_t head
);
	import rrts_pkg::*;

	slot_t cells [SLOTS];

	// Cell k takes from cell k+1 on a rotate, so the head walks up through the
	// slot numbers; the controller writes only the head.
	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		rrts_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.rotate(ctl.rotate),
			.clear_all(ctl.clear_all),
			.wr(ctl.wr && (k == 0)),
			.wr_data(ctl.data),
			.from_prev(cells[(k + 1) % SLOTS]),
			.slot(cells[k])
		);
	end

	assign head = cells[0];
endmodule

FILE: rtl/rrts_checker.sv
module rrts_checker (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [3:0] cur_slot,
	input logic [2:0] status
);
	import rrts_pkg::*;

	// Only one command at a time is in flight.
	a_no_accept_with_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !cmd_ready) else $error("command taken while response pending");

	// A taken command is not answered in the very next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !rsp_valid) else $error("response too early");

	// The current slot only changes while a command is in flight.
	a_cur_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ready && !(cmd_valid && cmd_ready)) |=> $stable(cur_slot))
		else $error("current slot changed while idle");

	// A held response keeps its status.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> $stable(status)) else $error("status changed");
endmodule

bind round_robin_task_scheduler_core rrts_checker u_rrts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.cur_slot(rsp.cur_slot),
	.status(rsp.status)
);
